/* src/gbts_pkg.sv */
package gbts_pkg;

  // Operation codes carried by the func field.
  localparam logic [1:0] OP_MOVE   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // Status codes returned with each result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Fill character after reset and the character returned by a bad read.
  localparam logic [7:0] FILL_RESET    = 8'd45;
  localparam logic [7:0] READ_ERR_CHAR = 8'd48;

  // A decoded command as it waits between the front and the back.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] position;
    logic [7:0] last_position;
    logic [7:0] char_in;
    logic       erase_inverted;
    logic       read_oob;
  } cmd_t;

  // Handshake and status from the back towards the front.
  typedef struct packed {
    logic take;
    logic clearing;
  } back_ctl_t;

  // One result item.
  typedef struct packed {
    logic [7:0] char_out;
    logic [8:0] cursor;
    logic [8:0] gap_stop;
    logic [8:0] free_cells;
    logic [8:0] text_length;
    logic [1:0] status;
  } res_t;

endpackage

/* src/gbts_ram.sv */
module gbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/gbts_front.sv */
module gbts_front #(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_position,
  input  logic [7:0]         in_last_position,
  input  logic [7:0]         in_char_in,
  input  gbts_pkg::back_ctl_t back_ctl,
  output logic               cmd_valid,
  output gbts_pkg::cmd_t     cmd
);

  import gbts_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;
  cmd_t       dec;

  // Classify the item: the checks that do not depend on the buffer state.
  always_comb begin
    dec.op             = in_func;
    dec.position       = in_position;
    dec.last_position  = in_last_position;
    dec.char_in        = in_char_in;
    dec.erase_inverted = (in_last_position < in_position);
    dec.read_oob       = (32'(in_position) >= 32'(CAPACITY));
  end

  // No item is taken while the back is still clearing the storage.
  assign full      = (count_r == 2'd2) || back_ctl.clearing;
  assign do_push   = push && !full;
  assign do_pop    = back_ctl.take && (count_r != 2'd0);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];

  // Pointer and count update for the two-entry queue.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

endmodule

/* src/gbts_back.sv */
module gbts_back #(
  parameter int CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                cmd_valid,
  input  gbts_pkg::cmd_t      cmd,
  output gbts_pkg::back_ctl_t back_ctl,
  input  logic                res_full,
  output logic                res_valid,
  output gbts_pkg::res_t      res
);

  import gbts_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int XW = PW + 8;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MOVE = 4'd2;
  localparam logic [3:0] S_SHW  = 4'd3;
  localparam logic [3:0] S_SHF  = 4'd4;
  localparam logic [3:0] S_INS  = 4'd5;
  localparam logic [3:0] S_ERA  = 4'd6;
  localparam logic [3:0] S_RDW  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [PW-1:0] gs_r, gs_nxt;
  logic [PW-1:0] ge_r, ge_nxt;
  logic [7:0]    fill_r;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    pos_r, pos_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic [8:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [AW-1:0] dst_r, dst_nxt;
  logic          left_r, left_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [7:0]    char_r, char_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [PW-1:0] free_w;
  logic [PW-1:0] tl_w;
  logic [XW-1:0] tl_x;
  logic [XW-1:0] gs_x;
  logic [XW-1:0] cpos_x;
  logic [XW-1:0] clast_x;
  logic [XW-1:0] tgt_x;
  logic [PW-1:0] gs_m1;
  logic [PW-1:0] ge_m1;
  logic [AW+7:0] cpos_a;

  // Zero-extends or truncates a pointer to the 9-bit result fields.
  function automatic logic [8:0] to9(input logic [PW-1:0] v);
    logic [PW+8:0] w;
    w = {9'b0, v};
    return w[8:0];
  endfunction

  gbts_ram #(
    .WIDTH(8),
    .DEPTH(CAPACITY)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Gap size, text length and widened operands for the compares.
  assign free_w  = ge_r - gs_r;
  assign tl_w    = CAP_P - free_w;
  assign tl_x    = {8'b0, tl_w};
  assign gs_x    = {8'b0, gs_r};
  assign cpos_x  = {{PW{1'b0}}, cmd.position};
  assign clast_x = {{PW{1'b0}}, cmd.last_position};
  assign tgt_x   = {{PW{1'b0}}, pos_r};
  assign gs_m1   = gs_r - PW'(1);
  assign ge_m1   = ge_r - PW'(1);
  assign cpos_a  = {{AW{1'b0}}, cmd.position};

  // Result fields follow the pointers as they stand when the item is done.
  assign res.char_out    = char_r;
  assign res.cursor      = to9(gs_r);
  assign res.gap_stop    = to9(ge_r);
  assign res.free_cells  = to9(free_w);
  assign res.text_length = to9(tl_w);
  assign res.status      = status_r;

  // Sequencer: one gap cell moves by a read, a copy and a fill.
  always_comb begin
    state_nxt         = state_r;
    gs_nxt            = gs_r;
    ge_nxt            = ge_r;
    clr_nxt           = clr_r;
    op_nxt            = op_r;
    pos_nxt           = pos_r;
    ch_nxt            = ch_r;
    cnt_nxt           = cnt_r;
    src_nxt           = src_r;
    dst_nxt           = dst_r;
    left_nxt          = left_r;
    status_nxt        = status_r;
    char_nxt          = char_r;
    ram_we            = 1'b0;
    ram_waddr         = gs_r[AW-1:0];
    ram_wdata         = fill_r;
    ram_re            = 1'b0;
    ram_raddr         = cpos_a[AW-1:0];
    back_ctl.take     = 1'b0;
    back_ctl.clearing = (state_r == S_CLR);
    res_valid         = 1'b0;
    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = FILL_RESET;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_A) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid && !res_full) begin
          back_ctl.take = 1'b1;
          op_nxt        = cmd.op;
          pos_nxt       = cmd.position;
          ch_nxt        = cmd.char_in;
          cnt_nxt       = {1'b0, cmd.last_position} - {1'b0, cmd.position} + 9'd1;
          char_nxt      = 8'd0;
          status_nxt    = ST_OK;
          state_nxt     = S_MOVE;
          case (cmd.op)
            OP_MOVE: begin
              if (cpos_x > tl_x) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end
            end
            OP_INSERT: begin
              if (cpos_x > tl_x) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else if (gs_r == ge_r) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end
            end
            OP_ERASE: begin
              if (cmd.erase_inverted || (clast_x >= tl_x)) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end
            end
            OP_READ: begin
              if (cmd.read_oob) begin
                char_nxt   = READ_ERR_CHAR;
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_RDW;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_MOVE: begin
        if (tgt_x < gs_x) begin
          // Shift left: the character before the gap goes to its far end.
          src_nxt   = gs_m1[AW-1:0];
          dst_nxt   = ge_m1[AW-1:0];
          left_nxt  = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = gs_m1[AW-1:0];
          state_nxt = S_SHW;
        end else if ((tgt_x > gs_x) && (ge_r < CAP_P)) begin
          // Shift right: the character after the gap goes to its near end.
          src_nxt   = ge_r[AW-1:0];
          dst_nxt   = gs_r[AW-1:0];
          left_nxt  = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = ge_r[AW-1:0];
          state_nxt = S_SHW;
        end else begin
          case (op_r)
            OP_INSERT: state_nxt = S_INS;
            OP_ERASE:  state_nxt = S_ERA;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_SHW: begin
        ram_we    = 1'b1;
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        state_nxt = S_SHF;
      end
      S_SHF: begin
        ram_we    = 1'b1;
        ram_waddr = src_r;
        ram_wdata = fill_r;
        if (left_r) begin
          gs_nxt = gs_r - PW'(1);
          ge_nxt = ge_r - PW'(1);
        end else begin
          gs_nxt = gs_r + PW'(1);
          ge_nxt = ge_r + PW'(1);
        end
        state_nxt = S_MOVE;
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = gs_r[AW-1:0];
        ram_wdata = ch_r;
        gs_nxt    = gs_r + PW'(1);
        state_nxt = S_DONE;
      end
      S_ERA: begin
        // Widen the gap over the erased range, one cell a cycle.
        if ((cnt_r != 9'd0) && (ge_r < CAP_P)) begin
          ram_we    = 1'b1;
          ram_waddr = ge_r[AW-1:0];
          ram_wdata = fill_r;
          ge_nxt    = ge_r + PW'(1);
          cnt_nxt   = cnt_r - 9'd1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDW: begin
        char_nxt  = ram_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and gap pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      gs_r    <= '0;
      ge_r    <= CAP_P;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      gs_r    <= gs_nxt;
      ge_r    <= ge_nxt;
    end
  end

  // Fill character register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= FILL_RESET;
    end else if (cfg_wr_en) begin
      fill_r <= cfg_wr_data;
    end
  end

  // Working copy of the current item.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    ch_r     <= ch_nxt;
    cnt_r    <= cnt_nxt;
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    left_r   <= left_nxt;
    status_r <= status_nxt;
    char_r   <= char_nxt;
  end

endmodule

/* src/gbts_resq.sv */
module gbts_resq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  gbts_pkg::res_t res,
  output logic           res_full,
  output logic           empty,
  input  logic           pop,
  output gbts_pkg::res_t head
);

  import gbts_pkg::*;

  res_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign res_full = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_pop   = pop && !empty;
  assign head     = slot_r[rd_ptr_r];

  // The back only starts an item when there is room, so a push always fits.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (res_valid) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (res_valid && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !res_valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      slot_r[wr_ptr_r] <= res;
    end
  end

endmodule

/* src/gap_buffer_text_store.sv */
// Flow: an item waits in the front queue until the executor takes it, and its result can be
// popped in the cycle after the executor finishes. A refused item goes straight to its result;
// a move shifts the gap cell by cell, an insert then writes its character and an erase then
// widens the gap over the erased cells. Each gap shift costs one storage read and two writes
// on the single write port. Items run one at a time, each taken only after the previous ends.
// Reset: storage is cleared to '-' cell by cell with full high; fill is '-', the gap spans all.
module gap_buffer_text_store #(
  parameter int CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_func,
  input  logic [7:0] in_position,
  input  logic [7:0] in_last_position,
  input  logic [7:0] in_char_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_out,
  output logic [8:0] out_cursor,
  output logic [8:0] out_gap_stop,
  output logic [8:0] out_free_cells,
  output logic [8:0] out_text_length,
  output logic [1:0] out_status,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  import gbts_pkg::*;

  back_ctl_t back_ctl;
  cmd_t      cmd;
  logic      cmd_valid;
  logic      res_full;
  logic      res_valid;
  res_t      res;
  res_t      head;

  // Front: input queue and item classification.
  gbts_front #(
    .CAPACITY(CAPACITY)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_last_position(in_last_position),
    .in_char_in      (in_char_in),
    .back_ctl        (back_ctl),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd)
  );

  // Back: gap sequencer and cell storage.
  gbts_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .back_ctl   (back_ctl),
    .res_full   (res_full),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result queue.
  gbts_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign out_char_out    = head.char_out;
  assign out_cursor      = head.cursor;
  assign out_gap_stop    = head.gap_stop;
  assign out_free_cells  = head.free_cells;
  assign out_text_length = head.text_length;
  assign out_status      = head.status;

endmodule
